/* design/signed_angle_about_normal_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the signed angle unit
// Immediate-consequence and fixed-delay property forms.
// ----------------------------------------------------------------------------
`ifndef SIGNED_ANGLE_ABOUT_NORMAL_UNIT_ASSERT_SVH
`define SIGNED_ANGLE_ABOUT_NORMAL_UNIT_ASSERT_SVH

// ante holds, then cons holds in the same cycle
`define SANU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds, then cons holds after the delay given by dly
`define SANU_ASSERT_DLY(name, clk, rst_n, ante, dly, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

/* design/sanu_pkg.sv */
// ----------------------------------------------------------------------------
// sanu_pkg
// Widths, pipeline tag type and arctangent table for the signed angle unit.
// ----------------------------------------------------------------------------
package sanu_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int NRM_W        = 16;
    localparam int EDGE_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int LO_W         = CROSS_W / 2;
    localparam int HI_W         = CROSS_W - LO_W;
    localparam int PH_W         = HI_W + NRM_W;
    localparam int PL_W         = LO_W + 1 + NRM_W;
    localparam int DET_W        = CROSS_W + NRM_W + 2;
    localparam int DOT_W        = PROD_W + 2;
    localparam int RES_W        = 31;
    localparam int U_W          = DET_W - RES_W + 1;
    localparam int SH_W         = $clog2(U_W + 1);
    localparam int XY_W         = RES_W + 3;
    localparam int Z_W          = 26;
    localparam int ANGLE_W      = 16;
    localparam int LATENCY      = 10 + CORDIC_STEPS;

    localparam logic signed [Z_W-1:0] HALF_PI   = Z_W'(4194304);
    localparam logic signed [Z_W-1:0] ROUND_ADD = Z_W'(128);

    typedef struct packed {
        logic valid;
        logic degen;
        logic zero;
    } t_tag;

    function automatic logic signed [Z_W-1:0] atan_unit(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = Z_W'(2097152);
            1:  v = Z_W'(1238021);
            2:  v = Z_W'(654136);
            3:  v = Z_W'(332050);
            4:  v = Z_W'(166669);
            5:  v = Z_W'(83416);
            6:  v = Z_W'(41718);
            7:  v = Z_W'(20860);
            8:  v = Z_W'(10430);
            9:  v = Z_W'(5215);
            10: v = Z_W'(2608);
            11: v = Z_W'(1304);
            12: v = Z_W'(652);
            13: v = Z_W'(326);
            14: v = Z_W'(163);
            15: v = Z_W'(81);
            16: v = Z_W'(41);
            17: v = Z_W'(20);
            18: v = Z_W'(10);
            19: v = Z_W'(5);
            20: v = Z_W'(3);
            21: v = Z_W'(1);
            22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/signed_angle_about_normal_unit.sv */
// One request is taken in every clock cycle: busy never rises. Each request
// gives one result on o_angle and o_degenerate, marked by o_strobe for one
// cycle. A request passes through the front products and triple product
// (5 stages), the shift search (3 stages), the quadrant pre-turn, the CORDIC
// chain of one micro-rotation per stage, and a final rounding register.
// Results cannot be held off; they follow requests in order.
// ----------------------------------------------------------------------------
// signed_angle_about_normal_unit
// Signed angle at a vertex about a reference normal, atan2 by CORDIC.
// ----------------------------------------------------------------------------
`include "signed_angle_about_normal_unit_assert.svh"

module signed_angle_about_normal_unit import sanu_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   i_first_x,
    input  logic signed [COORD_WIDTH-1:0]   i_first_y,
    input  logic signed [COORD_WIDTH-1:0]   i_first_z,
    input  logic signed [COORD_WIDTH-1:0]   i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0]   i_vertex_y,
    input  logic signed [COORD_WIDTH-1:0]   i_vertex_z,
    input  logic signed [COORD_WIDTH-1:0]   i_third_x,
    input  logic signed [COORD_WIDTH-1:0]   i_third_y,
    input  logic signed [COORD_WIDTH-1:0]   i_third_z,
    input  logic signed [NRM_W-1:0]         i_normal_x,
    input  logic signed [NRM_W-1:0]         i_normal_y,
    input  logic signed [NRM_W-1:0]         i_normal_z,
    output logic                            o_strobe,
    output logic signed [ANGLE_W-1:0]       o_angle,
    output logic                            o_degenerate
);

    logic signed [COORD_WIDTH-1:0] first [3];
    logic signed [COORD_WIDTH-1:0] vertex [3];
    logic signed [COORD_WIDTH-1:0] third [3];
    logic signed [NRM_W-1:0]       normal [3];
    t_tag                          front_tag, norm_tag;
    logic signed [DET_W-1:0]       det;
    logic signed [DOT_W-1:0]       dot;
    logic signed [RES_W-1:0]       nx, ny;
    logic                          req;

    assign busy = 1'b0;
    assign req  = start && !busy;

    assign first  = '{i_first_x, i_first_y, i_first_z};
    assign vertex = '{i_vertex_x, i_vertex_y, i_vertex_z};
    assign third  = '{i_third_x, i_third_y, i_third_z};
    assign normal = '{i_normal_x, i_normal_y, i_normal_z};

    sanu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (req),
        .i_first  (first),
        .i_vertex (vertex),
        .i_third  (third),
        .i_normal (normal),
        .o_tag    (front_tag),
        .o_det    (det),
        .o_dot    (dot)
    );

    sanu_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (front_tag),
        .i_det   (det),
        .i_dot   (dot),
        .o_tag   (norm_tag),
        .o_x     (nx),
        .o_y     (ny)
    );

    sanu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (norm_tag),
        .i_x     (nx),
        .i_y     (ny),
        .o_valid (o_strobe),
        .o_angle (o_angle),
        .o_degen (o_degenerate)
    );

    `SANU_ASSERT_DLY(a_req_gives_result, i_clk, i_rst_n, req, LATENCY, o_strobe, "lost result")
    `SANU_ASSERT_DLY(a_no_extra_result, i_clk, i_rst_n, !req, LATENCY, !o_strobe, "extra result")
    `SANU_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, o_strobe && o_degenerate, o_angle == '0, "degenerate angle not zero")

endmodule

/* design/sanu_front.sv */
// ----------------------------------------------------------------------------
// sanu_front
// Edge vectors, products, cross and dot, and the triple product with the
// normal, over five register stages.
// ----------------------------------------------------------------------------
module sanu_front import sanu_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [COORD_WIDTH-1:0]   i_first [3],
    input  logic signed [COORD_WIDTH-1:0]   i_vertex [3],
    input  logic signed [COORD_WIDTH-1:0]   i_third [3],
    input  logic signed [NRM_W-1:0]         i_normal [3],
    output t_tag                            o_tag,
    output logic signed [DET_W-1:0]         o_det,
    output logic signed [DOT_W-1:0]         o_dot
);

    logic signed [EDGE_W-1:0]  r_a [3];
    logic signed [EDGE_W-1:0]  r_b [3];
    logic signed [NRM_W-1:0]   r_n1 [3];
    logic signed [PROD_W-1:0]  r_p [3][3];
    logic signed [NRM_W-1:0]   r_n2 [3];
    logic                      r_dg2;
    logic signed [CROSS_W-1:0] r_cr [3];
    logic signed [DOT_W-1:0]   r_dot3;
    logic signed [NRM_W-1:0]   r_n3 [3];
    logic                      r_dg3;
    logic signed [PH_W-1:0]    r_ph [3];
    logic signed [PL_W-1:0]    r_pl [3];
    logic signed [DOT_W-1:0]   r_dot4;
    logic                      r_dg4;
    logic signed [DET_W-1:0]   r_det5;
    logic signed [DOT_W-1:0]   r_dot5;
    logic                      r_dg5;
    logic [4:0]                r_vld;
    logic signed [DET_W-1:0]   n_det;
    logic signed [DOT_W-1:0]   n_dot;
    logic signed [HI_W-1:0]    hi [3];
    logic signed [LO_W:0]      lo [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_a[k]  <= $signed({i_first[k][COORD_WIDTH-1], i_first[k]})
                     - $signed({i_vertex[k][COORD_WIDTH-1], i_vertex[k]});
            r_b[k]  <= $signed({i_third[k][COORD_WIDTH-1], i_third[k]})
                     - $signed({i_vertex[k][COORD_WIDTH-1], i_vertex[k]});
            r_n1[k] <= i_normal[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_p[i][j] <= PROD_W'(r_a[i]) * PROD_W'(r_b[j]);
            end
            r_n2[i] <= r_n1[i];
        end
        r_dg2 <= (r_a[0] == '0 && r_a[1] == '0 && r_a[2] == '0) ||
                 (r_b[0] == '0 && r_b[1] == '0 && r_b[2] == '0);
    end

    always_comb begin
        n_dot = DOT_W'(r_p[0][0]) + DOT_W'(r_p[1][1]) + DOT_W'(r_p[2][2]);
    end

    always_ff @(posedge i_clk) begin
        r_cr[0] <= CROSS_W'(r_p[1][2]) - CROSS_W'(r_p[2][1]);
        r_cr[1] <= CROSS_W'(r_p[2][0]) - CROSS_W'(r_p[0][2]);
        r_cr[2] <= CROSS_W'(r_p[0][1]) - CROSS_W'(r_p[1][0]);
        r_dot3  <= n_dot;
        r_n3    <= r_n2;
        r_dg3   <= r_dg2;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hi[k] = r_cr[k][CROSS_W-1:LO_W];
            lo[k] = $signed({1'b0, r_cr[k][LO_W-1:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ph[k] <= PH_W'(hi[k]) * PH_W'(r_n3[k]);
            r_pl[k] <= PL_W'(lo[k]) * PL_W'(r_n3[k]);
        end
        r_dot4 <= r_dot3;
        r_dg4  <= r_dg3;
    end

    always_comb begin
        n_det = '0;
        for (int k = 0; k < 3; k++) begin
            n_det = n_det + (DET_W'(r_ph[k]) <<< LO_W) + DET_W'(r_pl[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det5 <= n_det;
        r_dot5 <= r_dot4;
        r_dg5  <= r_dg4;
    end

    assign o_tag = '{valid: r_vld[4], degen: r_dg5, zero: 1'b0};
    assign o_det = r_det5;
    assign o_dot = r_dot5;

endmodule

/* design/sanu_norm.sv */
// ----------------------------------------------------------------------------
// sanu_norm
// Common right shift that brings det and dot into 31-bit range: sign
// spread, leading-bit search, then the shift, one register stage each.
// ----------------------------------------------------------------------------
module sanu_norm import sanu_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_tag                        i_tag,
    input  logic signed [DET_W-1:0]     i_det,
    input  logic signed [DOT_W-1:0]     i_dot,
    output t_tag                        o_tag,
    output logic signed [RES_W-1:0]     o_x,
    output logic signed [RES_W-1:0]     o_y
);

    t_tag                    r_t6, r_t7, r_t8;
    logic signed [DET_W-1:0] r_det6, r_dot6, r_det7, r_dot7;
    logic [U_W-1:0]          r_u;
    logic [SH_W-1:0]         r_s;
    logic signed [RES_W-1:0] r_x, r_y;
    logic signed [DET_W-1:0] dot_x, spread, shx, shy;
    logic [SH_W-1:0]         n_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t6.valid <= 1'b0;
            r_t7.valid <= 1'b0;
            r_t8.valid <= 1'b0;
        end else begin
            r_t6.valid <= i_tag.valid;
            r_t7.valid <= r_t6.valid;
            r_t8.valid <= r_t7.valid;
        end
        r_t6.degen <= i_tag.degen;
        r_t6.zero  <= (i_det == '0) && (i_dot == '0);
        r_t7.degen <= r_t6.degen;
        r_t7.zero  <= r_t6.zero;
        r_t8.degen <= r_t7.degen;
        r_t8.zero  <= r_t7.zero;
    end

    always_comb begin
        dot_x  = DET_W'(i_dot);
        spread = (i_det ^ {DET_W{i_det[DET_W-1]}}) | (dot_x ^ {DET_W{dot_x[DET_W-1]}});
    end

    always_ff @(posedge i_clk) begin
        r_det6     <= i_det;
        r_dot6     <= dot_x;
        r_u        <= spread[DET_W-1:RES_W-1];
    end

    always_comb begin
        n_s = '0;
        for (int i = 0; i < U_W; i++) begin
            if (r_u[i]) begin
                n_s = SH_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_det7     <= r_det6;
        r_dot7     <= r_dot6;
        r_s        <= n_s;
    end

    always_comb begin
        shx = r_dot7 >>> r_s;
        shy = r_det7 >>> r_s;
    end

    always_ff @(posedge i_clk) begin
        r_x        <= shx[RES_W-1:0];
        r_y        <= shy[RES_W-1:0];
    end

    assign o_tag = r_t8;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

/* design/sanu_cordic.sv */
// ----------------------------------------------------------------------------
// sanu_cordic
// Vectoring CORDIC: quadrant pre-turn, one micro-rotation per stage, then
// rounding to 16-bit binary angle units.
// ----------------------------------------------------------------------------
module sanu_cordic import sanu_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_tag                        i_tag,
    input  logic signed [RES_W-1:0]     i_x,
    input  logic signed [RES_W-1:0]     i_y,
    output logic                        o_valid,
    output logic signed [ANGLE_W-1:0]   o_angle,
    output logic                        o_degen
);

    logic signed [XY_W-1:0]  r_x [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]  r_y [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]   r_z [CORDIC_STEPS+1];
    t_tag                    r_t [CORDIC_STEPS+1];
    logic                    r_ov;
    logic signed [ANGLE_W-1:0] r_angle;
    logic                    r_degen;
    logic signed [XY_W-1:0]  xe, ye, n_x0, n_y0;
    logic signed [Z_W-1:0]   n_z0, rz;

    always_comb begin
        xe = XY_W'(i_x);
        ye = XY_W'(i_y);
        if (xe < 0) begin
            if (ye >= 0) begin
                n_x0 = ye;
                n_y0 = -xe;
                n_z0 = HALF_PI;
            end else begin
                n_x0 = -ye;
                n_y0 = xe;
                n_z0 = -HALF_PI;
            end
        end else begin
            n_x0 = xe;
            n_y0 = ye;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t[0].valid <= 1'b0;
        end else begin
            r_t[0].valid <= i_tag.valid;
        end
        r_x[0]       <= n_x0;
        r_y[0]       <= n_y0;
        r_z[0]       <= n_z0;
        r_t[0].degen <= i_tag.degen;
        r_t[0].zero  <= i_tag.zero;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_t[g+1].valid <= 1'b0;
            end else begin
                r_t[g+1].valid <= r_t[g].valid;
            end
            r_t[g+1].degen <= r_t[g].degen;
            r_t[g+1].zero  <= r_t[g].zero;
            if (r_y[g][XY_W-1]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - atan_unit(g);
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + atan_unit(g);
            end
        end
    end

    assign rz = r_z[CORDIC_STEPS] + ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_t[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_degen <= r_t[CORDIC_STEPS].degen;
        if (r_t[CORDIC_STEPS].degen || r_t[CORDIC_STEPS].zero) begin
            r_angle <= '0;
        end else begin
            r_angle <= rz[ANGLE_W+7:8];
        end
    end

    assign o_valid = r_ov;
    assign o_angle = r_angle;
    assign o_degen = r_degen;

endmodule
